/* rtl/bta_pkg.sv */
// Shared constants, codes and control/status types of the boundary-tag heap allocator.
package bta_pkg;

    localparam int HEAP_GRANULES = 4096;
    localparam int GRAN_SHIFT    = 4;
    localparam int ADDR_W        = $clog2(HEAP_GRANULES);
    localparam int SIZE_W        = ADDR_W + 1;
    localparam int WALK_W        = SIZE_W + 1;
    localparam int TAG_W         = SIZE_W + 1;
    localparam int DATA_W        = 16;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam logic [SIZE_W-1:0] SPLIT_MIN = SIZE_W'(3);

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_NEXT  = 2'd2;
    localparam logic [1:0] FIT_WORST = 2'd3;

    localparam logic REG_FIT_POLICY    = 1'b0;
    localparam logic REG_HEAP_GRANULES = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ZERO_SIZE   = 3'd1,
        ST_NO_SPACE    = 3'd2,
        ST_DOUBLE_FREE = 3'd3,
        ST_IGNORED     = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_RD_G,
        OP_ALLOC_EVAL,
        OP_NF_WRAP,
        OP_BUMP,
        OP_WR_SPLIT_HDR,
        OP_WR_SPLIT_FTR,
        OP_WR_PICK_HDR,
        OP_WR_PICK_FTR,
        OP_FREE_EVAL,
        OP_RD_R,
        OP_R_EVAL,
        OP_WR_FREE_HDR,
        OP_WR_FREE_FTR,
        OP_RD_HM1,
        OP_RD_L,
        OP_L_MERGE,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic cmd_free;
        logic bytes_zero;
        logic addr_bad;
        logic walk_ok;
        logic nf_mode;
        logic phase1;
        logic fit_stop;
        logic found;
        logic split;
        logic bump_fail;
        logic hit;
        logic in_block;
        logic tag_free;
        logic r_ok;
        logic h_zero;
        logic lf_bad;
        logic out_free;
    } sts_t;

endpackage

/* rtl/bta_ifs.sv */
// Request and response channel interfaces of the heap allocator.
interface bta_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] request_bytes;
    logic [15:0] block_address;

    modport source (output valid, command, request_bytes, block_address, input ready);
    modport sink   (input valid, command, request_bytes, block_address, output ready);
endinterface

interface bta_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_address;
    logic [2:0]  status;

    modport source (output valid, result_address, status, input ready);
    modport sink   (input valid, result_address, status, output ready);
endinterface

/* rtl/boundary_tag_heap_allocator_top.sv */
// Top level of the boundary-tag heap allocator: controller, datapath and APB config port.
// One request at a time; a new beat is taken only while the controller is idle.
// Allocate: a tag read and a fit evaluation per block walked, then an optional split and the
// header and footer writes. Free: a walk to find the header, a tag read per right merge, header
// and footer writes and two tag reads per left merge; a held result beat stalls the finish.
// Reset clears control state, heap to empty, first fit, 4096 granules; tag store is not cleared.
module boundary_tag_heap_allocator_top import bta_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    bta_req_if.sink            req,
    bta_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign pready    = 1'b1;
    assign req.ready = in_ready;

    bta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bta_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .in_command         (req.command),
        .in_request_bytes   (req.request_bytes),
        .in_block_address   (req.block_address),
        .out_valid          (rsp.valid),
        .out_ready          (rsp.ready),
        .out_result_address (rsp.result_address),
        .out_status         (rsp.status),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata)
    );

endmodule

/* rtl/bta_datapath.sv */
// Datapath: tag store, walk registers, heap state, result register and config registers.
module bta_datapath import bta_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               in_command,
    input  logic [DATA_W-1:0]  in_request_bytes,
    input  logic [DATA_W-1:0]  in_block_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DATA_W-1:0]  out_result_address,
    output logic [2:0]         out_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata
);

    logic [TAG_W-1:0]  mem [HEAP_GRANULES];
    logic [TAG_W-1:0]  rdata_reg;

    logic [1:0]        policy_reg;
    logic [SIZE_W-1:0] hg_reg;
    logic [SIZE_W-1:0] bump_reg;
    logic [ADDR_W-1:0] rover_reg;
    logic              out_valid_reg;

    logic              cmd_free_reg;
    logic              bytes_zero_reg;
    logic              addr_bad_reg;
    logic [SIZE_W-1:0] n_reg;
    logic [ADDR_W-1:0] h_reg;
    logic [WALK_W-1:0] g_reg;
    logic              phase_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] pick_reg;
    logic [SIZE_W-1:0] psize_reg;
    logic [SIZE_W-1:0] slack_reg;
    logic [SIZE_W-1:0] s_reg;
    logic [WALK_W-1:0] r_reg;
    logic [ADDR_W-1:0] l_reg;
    logic [DATA_W-1:0] res_addr_reg;
    logic [DATA_W-1:0] out_addr_reg;
    status_t           out_status_reg;

    logic              tag_free;
    logic [SIZE_W-1:0] tag_size;
    logic [WALK_W-1:0] g_after;
    logic [WALK_W-1:0] g_end;
    logic [WALK_W-1:0] bump_w;
    logic [WALK_W-1:0] h_w;
    logic              fit;
    logic              better;
    logic [SIZE_W-1:0] diff;
    logic [SIZE_W-1:0] rest;
    logic [SIZE_W-1:0] s_grow;
    logic [ADDR_W-1:0] l_calc;
    logic [SIZE_W-1:0] n_calc;
    logic              cfg_wr;

    logic              we;
    logic              re;
    logic [WALK_W-1:0] waddr_full;
    logic [TAG_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;

    assign tag_free = rdata_reg[TAG_W-1];
    assign tag_size = rdata_reg[SIZE_W-1:0];
    assign bump_w   = {1'b0, bump_reg};
    assign h_w      = {2'b0, h_reg};
    assign g_after  = g_reg + {1'b0, tag_size} + WALK_W'(2);
    assign g_end    = g_reg + {1'b0, tag_size} + WALK_W'(1);
    assign fit      = tag_free && (tag_size >= n_reg);
    assign diff     = tag_size - n_reg;
    assign rest     = psize_reg - n_reg - SIZE_W'(2);
    assign s_grow   = s_reg + tag_size + SIZE_W'(2);
    assign l_calc   = h_reg - tag_size[ADDR_W-1:0] - ADDR_W'(2);
    assign n_calc   = {1'b0, in_request_bytes[DATA_W-1:GRAN_SHIFT]}
                      + SIZE_W'(|in_request_bytes[GRAN_SHIFT-1:0]);
    assign cfg_wr   = psel && penable && pwrite;

    always_comb
    begin
        unique case (policy_reg)
            FIT_BEST:  better = !found_reg || (diff < slack_reg);
            FIT_WORST: better = diff >= slack_reg;
            FIT_FIRST: better = 1'b1;
            FIT_NEXT:  better = 1'b1;
            default:   better = 1'b1;
        endcase
    end

    always_comb
    begin
        sts.cmd_free   = cmd_free_reg;
        sts.bytes_zero = bytes_zero_reg;
        sts.addr_bad   = addr_bad_reg;
        sts.nf_mode    = policy_reg == FIT_NEXT;
        sts.phase1     = phase_reg;
        if (!cmd_free_reg && phase_reg)
        begin
            sts.walk_ok = (g_reg < {2'b0, rover_reg}) && (g_reg < bump_w);
        end
        else
        begin
            sts.walk_ok = g_reg < bump_w;
        end
        sts.fit_stop  = fit && (policy_reg == FIT_FIRST || policy_reg == FIT_NEXT);
        sts.found     = found_reg;
        sts.split     = (psize_reg - n_reg) >= SPLIT_MIN;
        sts.bump_fail = (bump_w + {1'b0, n_reg} + WALK_W'(2)) > {1'b0, hg_reg};
        sts.hit       = g_reg == h_w;
        sts.in_block  = (h_w > g_reg) && (h_w <= g_end);
        sts.tag_free  = tag_free;
        sts.r_ok      = r_reg < bump_w;
        sts.h_zero    = h_reg == '0;
        sts.lf_bad    = ({1'b0, tag_size} + WALK_W'(2)) > h_w;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        we         = 1'b0;
        re         = 1'b0;
        waddr_full = '0;
        wdata      = '0;
        raddr      = '0;
        unique case (cmd.op)
            OP_RD_G:
            begin
                re    = 1'b1;
                raddr = g_reg[ADDR_W-1:0];
            end
            OP_RD_R:
            begin
                re    = 1'b1;
                raddr = r_reg[ADDR_W-1:0];
            end
            OP_RD_HM1:
            begin
                re    = 1'b1;
                raddr = h_reg - ADDR_W'(1);
            end
            OP_RD_L:
            begin
                re    = 1'b1;
                raddr = l_calc;
            end
            OP_WR_SPLIT_HDR:
            begin
                we         = 1'b1;
                waddr_full = {2'b0, pick_reg} + {1'b0, n_reg} + WALK_W'(2);
                wdata      = {1'b1, rest};
            end
            OP_WR_SPLIT_FTR:
            begin
                we         = 1'b1;
                waddr_full = {2'b0, pick_reg} + {1'b0, psize_reg} + WALK_W'(1);
                wdata      = {1'b0, rest};
            end
            OP_WR_PICK_HDR:
            begin
                we         = 1'b1;
                waddr_full = {2'b0, pick_reg};
                wdata      = {1'b0, psize_reg};
            end
            OP_WR_PICK_FTR:
            begin
                we         = 1'b1;
                waddr_full = {2'b0, pick_reg} + {1'b0, psize_reg} + WALK_W'(1);
                wdata      = {1'b0, psize_reg};
            end
            OP_WR_FREE_HDR:
            begin
                we         = 1'b1;
                waddr_full = h_w;
                wdata      = {1'b1, s_reg};
            end
            OP_WR_FREE_FTR:
            begin
                we         = 1'b1;
                waddr_full = h_w + {1'b0, s_reg} + WALK_W'(1);
                wdata      = {1'b0, s_reg};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr_full[ADDR_W-1:0]] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= FIT_FIRST;
            hg_reg        <= SIZE_W'(HEAP_GRANULES);
            bump_reg      <= '0;
            rover_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == REG_HEAP_GRANULES)
                begin
                    if (pwdata[SIZE_W-1:0] > SIZE_W'(HEAP_GRANULES))
                    begin
                        hg_reg <= SIZE_W'(HEAP_GRANULES);
                    end
                    else
                    begin
                        hg_reg <= pwdata[SIZE_W-1:0];
                    end
                end
                else
                begin
                    policy_reg <= pwdata[1:0];
                end
                bump_reg  <= '0;
                rover_reg <= '0;
            end
            else
            begin
                unique case (cmd.op)
                    OP_ALLOC_EVAL:
                    begin
                        if (fit && policy_reg == FIT_NEXT)
                        begin
                            rover_reg <= g_reg[ADDR_W-1:0];
                        end
                    end
                    OP_BUMP:
                    begin
                        bump_reg <= bump_reg + n_reg + SIZE_W'(2);
                    end
                    OP_R_EVAL:
                    begin
                        if (tag_free && {2'b0, rover_reg} == r_reg)
                        begin
                            rover_reg <= h_reg;
                        end
                    end
                    OP_L_MERGE:
                    begin
                        if (rover_reg == h_reg)
                        begin
                            rover_reg <= l_reg;
                        end
                    end
                    default:
                    begin
                        rover_reg <= rover_reg;
                    end
                endcase
            end
            if (cmd.op == OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
            begin
                cmd_free_reg   <= in_command;
                bytes_zero_reg <= in_request_bytes == '0;
                addr_bad_reg   <= (in_block_address == '0)
                                  || (in_block_address[GRAN_SHIFT-1:0] != '0);
                n_reg          <= n_calc;
                h_reg          <= in_block_address[DATA_W-1:GRAN_SHIFT] - ADDR_W'(1);
                g_reg          <= (!in_command && policy_reg == FIT_NEXT)
                                  ? {2'b0, rover_reg} : '0;
                phase_reg      <= 1'b0;
                found_reg      <= 1'b0;
                slack_reg      <= '0;
                res_addr_reg   <= '0;
            end
            OP_NF_WRAP:
            begin
                g_reg     <= '0;
                phase_reg <= 1'b1;
            end
            OP_ALLOC_EVAL:
            begin
                if (fit && better)
                begin
                    pick_reg  <= g_reg[ADDR_W-1:0];
                    psize_reg <= tag_size;
                    slack_reg <= diff;
                    found_reg <= 1'b1;
                end
                g_reg <= g_after;
            end
            OP_BUMP:
            begin
                pick_reg  <= bump_reg[ADDR_W-1:0];
                psize_reg <= n_reg;
            end
            OP_WR_SPLIT_FTR:
            begin
                psize_reg <= n_reg;
            end
            OP_WR_PICK_FTR:
            begin
                res_addr_reg <= {pick_reg + ADDR_W'(1), {GRAN_SHIFT{1'b0}}};
            end
            OP_FREE_EVAL:
            begin
                if (g_reg == h_w)
                begin
                    s_reg <= tag_size;
                    r_reg <= h_w + {1'b0, tag_size} + WALK_W'(2);
                end
                else
                begin
                    g_reg <= g_after;
                end
            end
            OP_R_EVAL:
            begin
                if (tag_free)
                begin
                    s_reg <= s_grow;
                    r_reg <= h_w + {1'b0, s_grow} + WALK_W'(2);
                end
            end
            OP_RD_L:
            begin
                l_reg <= l_calc;
            end
            OP_L_MERGE:
            begin
                s_reg <= s_grow;
                h_reg <= l_reg;
            end
            OP_FINISH:
            begin
                out_addr_reg   <= res_addr_reg;
                out_status_reg <= cmd.code;
            end
            default:
            begin
                l_reg <= l_reg;
            end
        endcase
    end

    always_comb
    begin
        if (paddr[2] == REG_HEAP_GRANULES)
        begin
            prdata = {{(PDATA_W-SIZE_W){1'b0}}, hg_reg};
        end
        else
        begin
            prdata = {{(PDATA_W-2){1'b0}}, policy_reg};
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_result_address = out_addr_reg;
    assign out_status         = out_status_reg;

    a_bump_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg <= hg_reg)
        else $error("bump mark beyond heap size");

    a_rover_below_bump: assert property (@(posedge clk) disable iff (!rst_n)
        (rover_reg == '0) || ({1'b0, rover_reg} < bump_reg))
        else $error("rover outside used heap");

    a_write_below_bump: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (waddr_full < bump_w))
        else $error("tag write at or beyond bump mark");

endmodule

/* rtl/bta_ctrl.sv */
// Controller state machine sequencing allocate and free through the datapath.
module bta_ctrl import bta_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_CHK,
        S_A_EVAL,
        S_A_SPLIT,
        S_A_SPLIT2,
        S_A_BUMP,
        S_A_PHDR,
        S_A_PFTR,
        S_F_CHK,
        S_F_EVAL,
        S_R_CHK,
        S_R_EVAL,
        S_M_HDR,
        S_M_FTR,
        S_L_CHK,
        S_L_EVAL1,
        S_L_EVAL2,
        S_DONE
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t code_reg;
    status_t code_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = OP_NONE;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.cmd_free)
                begin
                    if (sts.addr_bad)
                    begin
                        code_next  = ST_IGNORED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_CHK;
                    end
                end
                else if (sts.bytes_zero)
                begin
                    code_next  = ST_ZERO_SIZE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                if (sts.walk_ok)
                begin
                    cmd.op     = OP_RD_G;
                    state_next = S_A_EVAL;
                end
                else if (sts.nf_mode && !sts.phase1)
                begin
                    cmd.op = OP_NF_WRAP;
                end
                else if (sts.found)
                begin
                    state_next = S_A_SPLIT;
                end
                else
                begin
                    state_next = S_A_BUMP;
                end
            end
            S_A_EVAL:
            begin
                cmd.op     = OP_ALLOC_EVAL;
                state_next = sts.fit_stop ? S_A_SPLIT : S_A_CHK;
            end
            S_A_SPLIT:
            begin
                if (sts.split)
                begin
                    cmd.op     = OP_WR_SPLIT_HDR;
                    state_next = S_A_SPLIT2;
                end
                else
                begin
                    state_next = S_A_PHDR;
                end
            end
            S_A_SPLIT2:
            begin
                cmd.op     = OP_WR_SPLIT_FTR;
                state_next = S_A_PHDR;
            end
            S_A_BUMP:
            begin
                if (sts.bump_fail)
                begin
                    code_next  = ST_NO_SPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_BUMP;
                    state_next = S_A_PHDR;
                end
            end
            S_A_PHDR:
            begin
                cmd.op     = OP_WR_PICK_HDR;
                state_next = S_A_PFTR;
            end
            S_A_PFTR:
            begin
                cmd.op     = OP_WR_PICK_FTR;
                code_next  = ST_OK;
                state_next = S_DONE;
            end
            S_F_CHK:
            begin
                if (sts.walk_ok)
                begin
                    cmd.op     = OP_RD_G;
                    state_next = S_F_EVAL;
                end
                else
                begin
                    code_next  = ST_IGNORED;
                    state_next = S_DONE;
                end
            end
            S_F_EVAL:
            begin
                cmd.op = OP_FREE_EVAL;
                priority if (sts.hit)
                begin
                    if (sts.tag_free)
                    begin
                        code_next  = ST_DOUBLE_FREE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_R_CHK;
                    end
                end
                else if (sts.in_block)
                begin
                    code_next  = sts.tag_free ? ST_DOUBLE_FREE : ST_IGNORED;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_F_CHK;
                end
            end
            S_R_CHK:
            begin
                if (sts.r_ok)
                begin
                    cmd.op     = OP_RD_R;
                    state_next = S_R_EVAL;
                end
                else
                begin
                    state_next = S_M_HDR;
                end
            end
            S_R_EVAL:
            begin
                cmd.op     = OP_R_EVAL;
                state_next = sts.tag_free ? S_R_CHK : S_M_HDR;
            end
            S_M_HDR:
            begin
                cmd.op     = OP_WR_FREE_HDR;
                state_next = S_M_FTR;
            end
            S_M_FTR:
            begin
                cmd.op     = OP_WR_FREE_FTR;
                state_next = S_L_CHK;
            end
            S_L_CHK:
            begin
                if (sts.h_zero)
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_HM1;
                    state_next = S_L_EVAL1;
                end
            end
            S_L_EVAL1:
            begin
                if (sts.lf_bad)
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_L;
                    state_next = S_L_EVAL2;
                end
            end
            S_L_EVAL2:
            begin
                if (sts.tag_free)
                begin
                    cmd.op     = OP_L_MERGE;
                    state_next = S_M_HDR;
                end
                else
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule
